// File: hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, register indexes and constants shared by the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CHAN_W     = 8;
    localparam int LUMA_SUM_W = 16;

    typedef enum logic [1:0] {
        FMT_ONE_BIT = 2'd0,
        FMT_GRAY8   = 2'd1,
        FMT_RGB24   = 2'd2,
        FMT_RGBA32  = 2'd3
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_FORMAT   = 2'd0,
        CFG_TARGET_FORMAT   = 2'd1,
        CFG_BLACK_THRESHOLD = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_fmt              source_format;
        t_fmt              target_format;
        logic [CHAN_W-1:0] black_threshold;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
        logic [CHAN_W-1:0] in_alpha;
        logic [CHAN_W-1:0] in_gray;
        logic              in_black;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic [CHAN_W-1:0] out_gray;
        logic              out_black;
    } t_pix_out;

    localparam t_fmt              RST_SOURCE_FORMAT   = FMT_GRAY8;
    localparam t_fmt              RST_TARGET_FORMAT   = FMT_GRAY8;
    localparam logic [CHAN_W-1:0] RST_BLACK_THRESHOLD = 8'd128;

    localparam logic [LUMA_SUM_W-1:0] LUMA_COEF_R = 16'd77;
    localparam logic [LUMA_SUM_W-1:0] LUMA_COEF_G = 16'd150;
    localparam logic [LUMA_SUM_W-1:0] LUMA_COEF_B = 16'd29;
    localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND  = 16'd128;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

endpackage

// File: hw/rtl/pfc_stream_if.sv
// ----------------------------------------------------------------------------
// pfc_stream_if
// Valid/ready channel carrying one pixel per transaction.
// ----------------------------------------------------------------------------
interface pfc_stream_if #(
    parameter type t_payload = logic
);

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// File: hw/rtl/pfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfc_cfg_regs
// Configuration register file: source format, target format, black threshold.
// ----------------------------------------------------------------------------
module pfc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pfc_pkg::t_cfg                    o_cfg
);

    pfc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_format   <= pfc_pkg::RST_SOURCE_FORMAT;
            r_cfg.target_format   <= pfc_pkg::RST_TARGET_FORMAT;
            r_cfg.black_threshold <= pfc_pkg::RST_BLACK_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (pfc_pkg::t_cfg_idx'(i_cfg_idx))
                pfc_pkg::CFG_SOURCE_FORMAT: begin
                    r_cfg.source_format <= pfc_pkg::t_fmt'(i_cfg_data[1:0]);
                end
                pfc_pkg::CFG_TARGET_FORMAT: begin
                    r_cfg.target_format <= pfc_pkg::t_fmt'(i_cfg_data[1:0]);
                end
                pfc_pkg::CFG_BLACK_THRESHOLD: begin
                    r_cfg.black_threshold <= i_cfg_data[pfc_pkg::CHAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/pfc_convert.sv
// ----------------------------------------------------------------------------
// pfc_convert
// Combinational conversion of one pixel from source to target format.
// ----------------------------------------------------------------------------
module pfc_convert (
    input  pfc_pkg::t_cfg     i_cfg,
    input  pfc_pkg::t_pix_in  i_pix,
    output pfc_pkg::t_pix_out o_pix
);

    logic [pfc_pkg::LUMA_SUM_W-1:0] w_luma_sum;
    logic [pfc_pkg::CHAN_W-1:0]     w_red;
    logic [pfc_pkg::CHAN_W-1:0]     w_green;
    logic [pfc_pkg::CHAN_W-1:0]     w_blue;
    logic [pfc_pkg::CHAN_W-1:0]     w_alpha;
    logic [pfc_pkg::CHAN_W-1:0]     w_level;
    logic                           w_black;

    // bt601 luma, max sum 65408 so no overflow
    assign w_luma_sum = ({8'd0, i_pix.in_red}   * pfc_pkg::LUMA_COEF_R)
                      + ({8'd0, i_pix.in_green} * pfc_pkg::LUMA_COEF_G)
                      + ({8'd0, i_pix.in_blue}  * pfc_pkg::LUMA_COEF_B)
                      + pfc_pkg::LUMA_ROUND;

    always_comb begin
        w_alpha = pfc_pkg::CHAN_FULL;
        case (i_cfg.source_format) inside
            pfc_pkg::FMT_ONE_BIT: begin
                w_black = i_pix.in_black;
                w_level = i_pix.in_black ? pfc_pkg::CHAN_ZERO : pfc_pkg::CHAN_FULL;
                w_red   = w_level;
                w_green = w_level;
                w_blue  = w_level;
            end
            pfc_pkg::FMT_GRAY8: begin
                w_level = i_pix.in_gray;
                w_red   = w_level;
                w_green = w_level;
                w_blue  = w_level;
                w_black = (w_level < i_cfg.black_threshold);
            end
            pfc_pkg::FMT_RGB24, pfc_pkg::FMT_RGBA32: begin
                w_red   = i_pix.in_red;
                w_green = i_pix.in_green;
                w_blue  = i_pix.in_blue;
                if (i_cfg.source_format == pfc_pkg::FMT_RGBA32) begin
                    w_alpha = i_pix.in_alpha;
                end
                w_level = w_luma_sum[pfc_pkg::LUMA_SUM_W-1 -: pfc_pkg::CHAN_W];
                w_black = (w_level < i_cfg.black_threshold);
            end
            default: begin
                w_red   = pfc_pkg::CHAN_ZERO;
                w_green = pfc_pkg::CHAN_ZERO;
                w_blue  = pfc_pkg::CHAN_ZERO;
                w_level = pfc_pkg::CHAN_ZERO;
                w_black = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_pix = '0;
        case (i_cfg.target_format) inside
            pfc_pkg::FMT_ONE_BIT: begin
                o_pix.out_black = w_black;
            end
            pfc_pkg::FMT_GRAY8: begin
                o_pix.out_gray = w_level;
            end
            pfc_pkg::FMT_RGB24, pfc_pkg::FMT_RGBA32: begin
                o_pix.out_red   = w_red;
                o_pix.out_green = w_green;
                o_pix.out_blue  = w_blue;
                if (i_cfg.target_format == pfc_pkg::FMT_RGBA32) begin
                    o_pix.out_alpha = w_alpha;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_converter
// Converts a pixel stream between one-bit, gray8, rgb24 and rgba32 formats.
// ----------------------------------------------------------------------------
// One pixel per transaction on i_pix, one converted pixel per transaction on
// o_pix. The block takes a new pixel every clock cycle while o_pix is not
// stalled. Each pixel is first held in the input register; the colour-to-gray
// multiply-add and the format selection follow it, and the result register
// holds the outcome and presents it on o_pix.
// A stall on o_pix holds the result register, and the input register fills
// behind it; pixels keep flowing as long as a stage is free. Formats and
// black threshold come from the write port (index 0 source format, 1 target
// format, 2 threshold) and are to be changed only while no pixel is in flight.
module pixel_format_converter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pfc_stream_if.sink                     i_pix,
    pfc_stream_if.source                   o_pix
);

    pfc_pkg::t_cfg     w_cfg;
    pfc_pkg::t_pix_out w_conv;

    logic              r_s1_valid;
    pfc_pkg::t_pix_in  r_s1_pix;
    logic              r_out_valid;
    pfc_pkg::t_pix_out r_out_pix;

    logic w_out_adv;
    logic w_s1_adv;

    pfc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    pfc_convert u_convert (
        .i_cfg (w_cfg),
        .i_pix (r_s1_pix),
        .o_pix (w_conv)
    );

    assign w_out_adv   = !r_out_valid || o_pix.ready;
    assign w_s1_adv    = !r_s1_valid || w_out_adv;
    assign i_pix.ready = w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= i_pix.valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_pix.valid) begin
            r_s1_pix <= i_pix.data;
        end
        if (w_out_adv && r_s1_valid) begin
            r_out_pix <= w_conv;
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out_pix;

endmodule

// File: sim/pixel_format_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_converter_tb
// Self-checking bench for the pixel format converter. A short table of
// directed pixels covers all format pairings but one-bit to rgb24, threshold
// edges and alpha handling. Random pixels follow under random settings, with source
// and sink stalls. Each output is checked against table values or the in-bench converter.
// ----------------------------------------------------------------------------
module pixel_format_converter_tb;
    import pfc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DIR_N       = 25;
    localparam int PHASE_PIX   = 250;

    typedef struct {
        logic       cfg_wr;
        t_fmt       src;
        t_fmt       tgt;
        logic [7:0] thr;
        t_pix_in    px;
        logic       typed;
        t_pix_out   want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pfc_stream_if #(.t_payload(t_pix_in))  pix_in_if ();
    pfc_stream_if #(.t_payload(t_pix_out)) pix_out_if ();

    pixel_format_converter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in_if),
        .o_pix      (pix_out_if)
    );

    // converter settings as the bench believes them to be
    t_fmt       fmt_src;
    t_fmt       fmt_tgt;
    logic [7:0] blk_thr;

    t_pix_out   pending_pix_q [$];
    t_dir_row   dir_tab [DIR_N];
    int         mismatch_cnt;
    int         idle_cycles;
    int         src_idle_pct;
    int         sink_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_pix_in in_px(input logic [7:0] r, g, b, a, gr, input logic bk);
        t_pix_in p;
        p.in_red   = r;
        p.in_green = g;
        p.in_blue  = b;
        p.in_alpha = a;
        p.in_gray  = gr;
        p.in_black = bk;
        return p;
    endfunction

    function automatic t_pix_out out_px(input logic [7:0] r, g, b, a, gr, input logic bk);
        t_pix_out p;
        p.out_red   = r;
        p.out_green = g;
        p.out_blue  = b;
        p.out_alpha = a;
        p.out_gray  = gr;
        p.out_black = bk;
        return p;
    endfunction

    function automatic t_pix_out convert_pixel(input t_pix_in p);
        t_pix_out    o;
        logic [7:0]  r, g, b, a, level;
        logic        blk;
        int unsigned wsum;
        o = '0;
        a = 8'd255;
        if (fmt_src == FMT_ONE_BIT) begin
            blk   = p.in_black;
            level = p.in_black ? 8'd0 : 8'd255;
            r = level;
            g = level;
            b = level;
        end else if (fmt_src == FMT_GRAY8) begin
            level = p.in_gray;
            r = level;
            g = level;
            b = level;
            blk = (level < blk_thr);
        end else begin
            r = p.in_red;
            g = p.in_green;
            b = p.in_blue;
            if (fmt_src == FMT_RGBA32) begin
                a = p.in_alpha;
            end
            wsum  = 77 * r + 150 * g + 29 * b + 128;
            level = 8'(wsum >> 8);
            blk   = (level < blk_thr);
        end
        case (fmt_tgt)
            FMT_ONE_BIT: begin
                o.out_black = blk;
            end
            FMT_GRAY8: begin
                o.out_gray = level;
            end
            default: begin
                o.out_red   = r;
                o.out_green = g;
                o.out_blue  = b;
                if (fmt_tgt == FMT_RGBA32) begin
                    o.out_alpha = a;
                end
            end
        endcase
        return o;
    endfunction

    task automatic push_pixel(input t_pix_in px, input t_pix_out want);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in_if.valid <= 1'b1;
        pix_in_if.data  <= px;
        @(posedge i_clk);
        while (!pix_in_if.ready) @(posedge i_clk);
        pending_pix_q.push_back(want);
    endtask

    task automatic wait_drained();
        pix_in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pix_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // upper bits of the format writes are random, only the low two count
    task automatic load_settings(input t_fmt src, input t_fmt tgt, input logic [7:0] thr);
        write_reg(CFG_UNUSED, 8'($urandom));
        write_reg(CFG_SOURCE_FORMAT, {6'($urandom), src});
        write_reg(CFG_TARGET_FORMAT, {6'($urandom), tgt});
        write_reg(CFG_BLACK_THRESHOLD, thr);
        i_cfg_we <= 1'b0;
        fmt_src  = src;
        fmt_tgt  = tgt;
        blk_thr  = thr;
    endtask

    // output side: random ready, check each transaction
    always @(posedge i_clk) begin
        t_pix_out want;
        t_pix_out got;
        if (!i_rst_n) begin
            pix_out_if.ready <= 1'b0;
        end else begin
            if (pix_out_if.valid && pix_out_if.ready) begin
                got = pix_out_if.data;
                if (pending_pix_q.size() == 0) begin
                    if (mismatch_cnt < 10) begin
                        $display("unexpected pixel: got %p", got);
                    end
                    mismatch_cnt++;
                end else begin
                    want = pending_pix_q.pop_front();
                    if (got.out_red !== want.out_red || got.out_green !== want.out_green
                        || got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha
                        || got.out_gray !== want.out_gray
                        || got.out_black !== want.out_black) begin
                        if (mismatch_cnt < 10) begin
                            $display("pixel mismatch: expected %p", want);
                            $display("                got      %p", got);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            pix_out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((pix_in_if.valid && pix_in_if.ready)
                     || (pix_out_if.valid && pix_out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_pix_in px;
        int      sent;
        int      seg_len;
        t_fmt    rs;
        t_fmt    rt;
        logic [7:0] rthr;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_SOURCE_FORMAT;
        i_cfg_data       = '0;
        pix_in_if.valid  = 1'b0;
        pix_in_if.data   = '0;
        mismatch_cnt     = 0;
        src_idle_pct     = 12;
        sink_idle_pct    = 88;
        fmt_src          = FMT_GRAY8;
        fmt_tgt          = FMT_GRAY8;
        blk_thr          = 8'd128;

        dir_tab = '{
            // settings straight out of reset
            '{1'b0, FMT_GRAY8, FMT_GRAY8, 8'd128, in_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b0, FMT_GRAY8, FMT_GRAY8, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0)},
            '{1'b1, FMT_ONE_BIT, FMT_RGBA32, 8'd128, in_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0)},
            '{1'b0, FMT_ONE_BIT, FMT_RGBA32, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0),
              1'b1, out_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0)},
            '{1'b1, FMT_ONE_BIT, FMT_ONE_BIT, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1)},
            '{1'b0, FMT_ONE_BIT, FMT_ONE_BIT, 8'd128, in_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_ONE_BIT, FMT_GRAY8, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b0, FMT_ONE_BIT, FMT_GRAY8, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0)},
            // threshold edges
            '{1'b1, FMT_GRAY8, FMT_ONE_BIT, 8'd0, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_GRAY8, FMT_ONE_BIT, 8'd255, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFE, 1'b0),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1)},
            '{1'b0, FMT_GRAY8, FMT_ONE_BIT, 8'd255, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_GRAY8, FMT_ONE_BIT, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 1'b0),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1)},
            '{1'b0, FMT_GRAY8, FMT_ONE_BIT, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_GRAY8, FMT_RGB24, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'hFF, 8'h5A, 1'b0),
              1'b1, out_px(8'h5A, 8'h5A, 8'h5A, 8'h00, 8'h00, 1'b0)},
            // alpha added, carried and dropped
            '{1'b1, FMT_RGB24, FMT_RGBA32, 8'd128, in_px(8'h11, 8'h22, 8'h33, 8'h12, 8'hEE, 1'b1),
              1'b1, out_px(8'h11, 8'h22, 8'h33, 8'hFF, 8'h00, 1'b0)},
            '{1'b1, FMT_RGBA32, FMT_RGBA32, 8'd128, in_px(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'hFF, 1'b1),
              1'b1, out_px(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h00, 1'b0)},
            '{1'b1, FMT_RGBA32, FMT_RGB24, 8'd128, in_px(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'hFF, 1'b1),
              1'b1, out_px(8'hA5, 8'h5A, 8'hC3, 8'h00, 8'h00, 1'b0)},
            // luma extremes and mid values
            '{1'b1, FMT_RGB24, FMT_GRAY8, 8'd128, in_px(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0)},
            '{1'b0, FMT_RGB24, FMT_GRAY8, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1),
              1'b1, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b0, FMT_RGB24, FMT_GRAY8, 8'd128, in_px(8'h80, 8'h40, 8'h20, 8'h00, 8'h00, 1'b0),
              1'b0, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_RGBA32, FMT_GRAY8, 8'd128, in_px(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0),
              1'b0, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_RGB24, FMT_ONE_BIT, 8'd128, in_px(8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 1'b1),
              1'b0, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_RGBA32, FMT_ONE_BIT, 8'd255, in_px(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1),
              1'b0, out_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_RGB24, FMT_RGB24, 8'd128, in_px(8'hFF, 8'h00, 8'hFF, 8'hAB, 8'hCD, 1'b1),
              1'b1, out_px(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0)},
            '{1'b1, FMT_GRAY8, FMT_RGBA32, 8'd128, in_px(8'h00, 8'h00, 8'h00, 8'h00, 8'h33, 1'b0),
              1'b1, out_px(8'h33, 8'h33, 8'h33, 8'hFF, 8'h00, 1'b0)}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg_wr) begin
                wait_drained();
                load_settings(dir_tab[i].src, dir_tab[i].tgt, dir_tab[i].thr);
            end
            push_pixel(dir_tab[i].px,
                       dir_tab[i].typed ? dir_tab[i].want : convert_pixel(dir_tab[i].px));
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 12;
                    sink_idle_pct = 88;
                end
                1: begin
                    src_idle_pct  = 88;
                    sink_idle_pct = 12;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_PIX) begin
                rs = t_fmt'($urandom_range(3));
                rt = t_fmt'($urandom_range(3));
                case ($urandom_range(3))
                    0:       rthr = 8'd0;
                    1:       rthr = 8'd255;
                    default: rthr = 8'($urandom);
                endcase
                wait_drained();
                load_settings(rs, rt, rthr);
                seg_len = $urandom_range(15, 40);
                for (int k = 0; k < seg_len; k++) begin
                    px = in_px(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 1'($urandom));
                    // gray levels right at the threshold
                    if ($urandom_range(3) == 0) begin
                        px.in_gray = blk_thr - 8'($urandom_range(1));
                    end
                    push_pixel(px, convert_pixel(px));
                end
                sent += seg_len;
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_pix_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
